// File: sv/unordered_value_table_defines.svh
// Assertion macros shared by the value table checker.
// Depends on nothing; included by files that assert.
`ifndef UNORDERED_VALUE_TABLE_DEFINES_SVH
`define UNORDERED_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UVT_ASSERT_IMP(label, ck, rst_n, pre, post) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("uvt assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define UVT_ASSERT_NXT(label, ck, rst_n, pre, post) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("uvt assertion failed");

`endif

// File: sv/uvt_pkg.sv
// Package for the unordered value table: op and status codes, field widths,
// controller/datapath interface structs. No dependencies.
package uvt_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Port field widths
	localparam int OP_W      = 3;
	localparam int KEY_W     = 32;
	localparam int POS_W     = 4;
	localparam int CNT_W     = 5;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 24;

	// Operation codes
	localparam logic [OP_W-1:0] OP_FIND         = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT       = 3'd1;
	localparam logic [OP_W-1:0] OP_UPDATE       = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE_FIRST = 3'd3;
	localparam logic [OP_W-1:0] OP_REMOVE_ALL   = 3'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUP       = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
		logic load;
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} sts_t;

	// One result item
	typedef struct packed {
		logic [CNT_W-1:0] fill_count;
		logic [CNT_W-1:0] removed_count;
		logic [POS_W-1:0] position;
		logic             found;
		status_t          status;
	} res_t;

endpackage

// File: sv/uvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/uvt_ctrl.sv
// Controller for the unordered value table: sequences accept, scan, commit
// and result hand-off. Depends on uvt_pkg.
module uvt_ctrl
	import uvt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_COMMIT = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q, state_nxt;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: sv/uvt_dp.sv
// Datapath for the unordered value table: entry RAM, scan pointers, match and
// compaction logic, result and output registers. Depends on uvt_pkg, uvt_ram.
module uvt_dp
	import uvt_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [OP_W-1:0]         op,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [KEY_W-1:0] new_value,
	input  logic                    out_ready,
	output logic                    out_valid,
	output res_t                    out_res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Request registers
	logic [OP_W-1:0]       op_q;
	logic [DATA_WIDTH-1:0] key_q, nv_q;

	// Scan state
	logic [CW-1:0] used_q, rd_q, wr_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic          hit_q;
	logic [AW-1:0] pos_q;

	// Result and output
	res_t res_q, out_q;
	logic out_valid_q;

	// RAM port
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata, rdata;

	// Sign extension of the 32-bit fields into a table word
	logic [63:0] key_ext, nv_ext;
	assign key_ext = {{32{key[KEY_W-1]}}, key};
	assign nv_ext  = {{32{new_value[KEY_W-1]}}, new_value};

	logic match, first, is_remove, keep, full;
	assign match     = vld_s1 && (rdata == key_q);
	assign first     = match && !hit_q;
	assign is_remove = (op_q == OP_REMOVE_FIRST) || (op_q == OP_REMOVE_ALL);
	assign keep      = !(match && ((op_q == OP_REMOVE_ALL) ||
		((op_q == OP_REMOVE_FIRST) && !hit_q)));
	assign full      = (used_q == CW'(DEPTH));

	assign sts.scan_done = (rd_q == used_q) && !vld_s1;
	assign sts.out_free  = !out_valid_q || out_ready;

	uvt_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_q[AW-1:0]),
		.rdata(rdata)
	);

	// Write port: update hit or compaction during scan, append on commit
	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = rdata;
		if (cmd.scan && vld_s1) begin
			if ((op_q == OP_UPDATE) && first) begin
				we    = 1'b1;
				wdata = nv_q;
			end else if (is_remove && keep) begin
				we    = 1'b1;
				waddr = wr_q[AW-1:0];
			end
		end else if (cmd.commit && (op_q == OP_INSERT) && !hit_q && !full) begin
			we    = 1'b1;
			waddr = used_q[AW-1:0];
			wdata = key_q;
		end
	end

	// Result of the request, evaluated on commit
	res_t          res_nxt;
	logic [CW-1:0] used_nxt;
	logic [AW-1:0] pos_nxt;
	logic [CW-1:0] removed;
	always_comb begin
		used_nxt = used_q;
		pos_nxt  = pos_q;
		removed  = '0;
		res_nxt  = '0;
		res_nxt.found  = hit_q;
		res_nxt.status = hit_q ? ST_OK : ST_NOT_FOUND;
		unique case (op_q) inside
			OP_INSERT: begin
				if (hit_q) begin
					res_nxt.status = ST_DUP;
				end else if (full) begin
					res_nxt.status = ST_FULL;
				end else begin
					res_nxt.status = ST_OK;
					pos_nxt        = used_q[AW-1:0];
					used_nxt       = used_q + CW'(1);
				end
			end
			OP_REMOVE_FIRST, OP_REMOVE_ALL: begin
				if (hit_q) begin
					used_nxt = wr_q;
					removed  = used_q - wr_q;
				end
			end
			default: begin
			end
		endcase
		res_nxt.position      = POS_W'((AW + POS_W)'(pos_nxt));
		res_nxt.removed_count = CNT_W'((CW + CNT_W)'(removed));
		res_nxt.fill_count    = CNT_W'((CW + CNT_W)'(used_nxt));
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				rd_q   <= '0;
				wr_q   <= '0;
				vld_s1 <= 1'b0;
				hit_q  <= 1'b0;
			end else if (cmd.scan) begin
				// issue one read per cycle, compare it the next
				vld_s1 <= (rd_q != used_q);
				if (rd_q != used_q) begin
					rd_q <= rd_q + CW'(1);
				end
				if (first) begin
					hit_q <= 1'b1;
				end
				if (vld_s1 && is_remove && keep) begin
					wr_q <= wr_q + CW'(1);
				end
			end
			if (cmd.commit) begin
				used_q <= used_nxt;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= op;
			key_q <= key_ext[DATA_WIDTH-1:0];
			nv_q  <= nv_ext[DATA_WIDTH-1:0];
			pos_q <= '0;
		end else if (cmd.scan && first) begin
			pos_q <= idx_s1;
		end
		if (cmd.scan) begin
			idx_s1 <= rd_q[AW-1:0];
		end
		if (cmd.commit) begin
			res_q <= res_nxt;
		end
		if (cmd.load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// File: sv/unordered_value_table.sv
// Unordered value table: a packed table of DEPTH signed words with a fill
// count, searched linearly from index 0. One request is in work at a time.
// The entry RAM is read once per cycle over the live entries (find, insert,
// update and both removes share this single pass, with removes compacting in
// place through the RAM write port); the scan ends once the last read has been
// compared, as the RAM read data is registered. A commit state then updates the
// fill count and the result, which is loaded into the output register once that
// is free, after which the next request can be accepted. The output register
// holds a finished result until taken, and the next request is accepted while
// it waits. Freed slots are never read again, so no clearing pass is needed
// after reset.
// Depends on uvt_pkg, uvt_ctrl, uvt_dp, uvt_ram.
module unordered_value_table
	import uvt_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// s_tdata: op[2:0], key[34:3], new_value[66:35], zero pad [71:67]
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// m_tdata: status[1:0], found[2], position[6:3], removed_count[11:7],
	// fill_count[16:12], zero pad [23:17]
	output logic [M_TDATA_W-1:0] m_tdata
);

	cmd_t cmd;
	sts_t sts;
	res_t res;

	logic [OP_W-1:0]         op;
	logic signed [KEY_W-1:0] key, new_value;

	// Unpack the request item
	assign op        = s_tdata[OP_W-1:0];
	assign key       = s_tdata[OP_W+KEY_W-1:OP_W];
	assign new_value = s_tdata[OP_W+2*KEY_W-1:OP_W+KEY_W];

	uvt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	uvt_dp #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.op       (op),
		.key      (key),
		.new_value(new_value),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_res  (res)
	);

	// Pack the result item
	assign m_tdata = {{(M_TDATA_W - $bits(res_t)){1'b0}}, res};

endmodule

// File: sv/uvt_checker.sv
// Port-level checker for the unordered value table, bound to the top level.
// Depends on uvt_pkg and unordered_value_table_defines.svh.
`include "unordered_value_table_defines.svh"

module uvt_checker
	import uvt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic    acc_in, unused_in;
	res_t    res;
	assign acc_in    = s_tvalid && s_tready;
	assign unused_in = ^s_tdata;
	assign res       = m_tdata[$bits(res_t)-1:0];

	// A held result keeps its value
	`UVT_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))

	// One request at a time: busy right after an accept
	`UVT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, acc_in || (unused_in && 1'b0),
		!s_tready)

	// Miss or full reports no match and removes nothing
	`UVT_ASSERT_IMP(a_miss_clean, clk, arst_n,
		m_tvalid && ((res.status == ST_NOT_FOUND) || (res.status == ST_FULL)),
		!res.found && (res.removed_count == '0))

	// Entries only go away on a match
	`UVT_ASSERT_IMP(a_remove_needs_hit, clk, arst_n,
		m_tvalid && (res.removed_count != '0),
		res.found && (res.status == ST_OK))

endmodule

bind unordered_value_table uvt_checker u_uvt_checker (.*);
